// ----- hw/rtl/crc8_frame_receiver_macros.svh -----
// ---------------------------------------------------------------------------
// crc8_frame_receiver_macros.svh
// Assertion macros used by the frame receiver checker.
// ---------------------------------------------------------------------------
`ifndef CRC8_FRAME_RECEIVER_MACROS_SVH
`define CRC8_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication, disabled while reset is active
`define CRC8FR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("crc8_frame_receiver: assertion failed");

// Next-cycle implication, disabled while reset is active
`define CRC8FR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("crc8_frame_receiver: assertion failed");

`endif

// ----- hw/rtl/crc8fr_pkg.sv -----
// ---------------------------------------------------------------------------
// crc8fr_pkg
// Types, codes and the CRC8 byte step shared by the frame receiver files.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package crc8fr_pkg;

    // Default width of the inter-byte tick counter
    localparam int unsigned TICK_WIDTH_DEFAULT = 16;

    // Input item kinds
    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // Result status codes
    typedef logic [1:0] status_t;
    localparam status_t STATUS_NONE     = 2'd0;
    localparam status_t STATUS_ACCEPT   = 2'd1;
    localparam status_t STATUS_MISMATCH = 2'd2;
    localparam status_t STATUS_TIMEOUT  = 2'd3;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_MASTER_ADDRESS = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_TICKS  = 1'd1;
    localparam int unsigned CFG_DATA_W = 16;

    // Configuration reset values
    localparam logic [7:0]  MASTER_ADDRESS_RESET = 8'd1;
    localparam logic [15:0] TIMEOUT_TICKS_RESET  = 16'd10;

    // Frame byte positions (by count of bytes already held)
    typedef logic [2:0] byte_pos_t;
    localparam byte_pos_t POS_COMMAND = 3'd1;
    localparam byte_pos_t POS_DATA_HI = 3'd2;
    localparam byte_pos_t POS_DATA_LO = 3'd3;
    localparam byte_pos_t FRAME_BYTES = 3'd5;

    // CRC8 generator, reflected form
    localparam logic [7:0] CRC8_GENERATOR = 8'h91;

    // Fold one byte into the CRC: XOR in, then eight shift rounds
    function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] r;
        r = acc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (r[0])
            begin
                r = r ^ CRC8_GENERATOR;
            end
            r = r >> 1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/crc8_frame_receiver.sv -----
// An accepted item's result is loaded into the output register in the next cycle.
// One item per cycle unless a waiting result stalls the input; the whole step
// is one pass of frame logic and a single CRC8 byte fold between state and output.
// Reset: rst_n clears the frame (receiver idle, tick counter saturated), loads
// master_address = 1 and timeout_ticks = 10, and empties the output register.
// ---------------------------------------------------------------------------
// crc8_frame_receiver
// Five-byte frame receiver with running CRC8 check and inter-byte timeout.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crc8_frame_receiver #(
    parameter int unsigned TICK_WIDTH = crc8fr_pkg::TICK_WIDTH_DEFAULT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // input channel
    input  wire logic                               in_valid,
    output      logic                               in_stall,
    input  wire logic                               func,
    input  wire logic [7:0]                         rx_byte,
    // result channel
    output      logic                               out_valid,
    input  wire logic                               out_stall,
    output      crc8fr_pkg::status_t                status,
    output      logic [7:0]                         frame_command,
    output      logic [15:0]                        frame_data,
    output      logic [7:0]                         frame_crc,
    // configuration write channel
    input  wire logic                               cfg_valid,
    output      logic                               cfg_ready,
    input  wire logic [crc8fr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [crc8fr_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int unsigned CMP_W = (TICK_WIDTH > 16) ? TICK_WIDTH : 16;
    localparam logic [TICK_WIDTH-1:0] TICK_MAX = {TICK_WIDTH{1'b1}};

    // Configuration registers
    logic [7:0]             master_address_reg;
    logic [15:0]            timeout_ticks_reg;

    // Frame state
    logic [7:0]             held_address_reg, held_address_next;
    logic [7:0]             held_command_reg, held_command_next;
    logic [15:0]            held_data_reg, held_data_next;
    logic [7:0]             held_crc_reg, held_crc_next;
    crc8fr_pkg::byte_pos_t  byte_count_reg, byte_count_next;
    logic [TICK_WIDTH-1:0]  idle_ticks_reg, idle_ticks_next;
    logic [7:0]             crc_acc_reg, crc_acc_next;

    // Output register
    logic                   out_valid_reg;
    crc8fr_pkg::status_t    status_reg, status_next;
    logic [7:0]             frame_command_reg, frame_command_next;
    logic [15:0]            frame_data_reg, frame_data_next;
    logic [7:0]             frame_crc_reg, frame_crc_next;

    logic                   accept;
    logic                   frame_clear;
    logic                   in_time;

    // Take a new item whenever the output register is empty or being drained
    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign in_time = CMP_W'(idle_ticks_reg) < CMP_W'(timeout_ticks_reg);

    // Frame step
    always_comb
    begin
        held_address_next  = held_address_reg;
        held_command_next  = held_command_reg;
        held_data_next     = held_data_reg;
        held_crc_next      = held_crc_reg;
        byte_count_next    = byte_count_reg;
        idle_ticks_next    = idle_ticks_reg;
        crc_acc_next       = crc_acc_reg;
        status_next        = crc8fr_pkg::STATUS_NONE;
        frame_command_next = 8'd0;
        frame_data_next    = 16'd0;
        frame_crc_next     = 8'd0;
        frame_clear        = 1'b0;

        if (accept)
        begin
            if (func == crc8fr_pkg::FUNC_TICK)
            begin
                // Advance the idle counter, saturating
                if (idle_ticks_reg != TICK_MAX)
                begin
                    idle_ticks_next = idle_ticks_reg + 1'b1;
                end
            end
            else
            begin
                priority if (rx_byte == master_address_reg && held_address_reg == 8'd0)
                begin
                    // Open a new frame on the master address
                    held_address_next = rx_byte;
                    byte_count_next   = crc8fr_pkg::POS_COMMAND;
                    idle_ticks_next   = '0;
                    crc_acc_next      = crc8fr_pkg::crc8_step(8'd0, rx_byte);
                end
                else if (in_time)
                begin
                    // Store the byte at its position; fold all but the CRC byte into the CRC
                    if (held_address_reg == master_address_reg
                        && byte_count_reg < crc8fr_pkg::FRAME_BYTES)
                    begin
                        unique case (byte_count_reg)
                            crc8fr_pkg::POS_COMMAND:
                            begin
                                held_command_next = rx_byte;
                                crc_acc_next = crc8fr_pkg::crc8_step(crc_acc_reg, rx_byte);
                            end
                            crc8fr_pkg::POS_DATA_HI:
                            begin
                                held_data_next = {rx_byte, held_data_reg[7:0]};
                                crc_acc_next = crc8fr_pkg::crc8_step(crc_acc_reg, rx_byte);
                            end
                            crc8fr_pkg::POS_DATA_LO:
                            begin
                                held_data_next = {held_data_reg[15:8], rx_byte};
                                crc_acc_next = crc8fr_pkg::crc8_step(crc_acc_reg, rx_byte);
                            end
                            default:
                            begin
                                held_crc_next = rx_byte;
                            end
                        endcase
                        byte_count_next = byte_count_reg + 3'd1;
                        idle_ticks_next = '0;
                    end
                end
                else
                begin
                    // Timed out: drop the frame and lose the byte
                    frame_clear = 1'b1;
                    if (held_address_reg != 8'd0 || byte_count_reg != 3'd0)
                    begin
                        status_next = crc8fr_pkg::STATUS_TIMEOUT;
                    end
                end

                // Check a complete frame against its CRC byte
                if (!frame_clear && byte_count_next >= crc8fr_pkg::FRAME_BYTES)
                begin
                    if (crc_acc_next == held_crc_next)
                    begin
                        status_next        = crc8fr_pkg::STATUS_ACCEPT;
                        frame_command_next = held_command_next;
                        frame_data_next    = held_data_next;
                        frame_crc_next     = held_crc_next;
                        frame_clear        = 1'b1;
                    end
                    else
                    begin
                        status_next = crc8fr_pkg::STATUS_MISMATCH;
                    end
                end
            end

            // Return to idle with the timeout already expired
            if (frame_clear)
            begin
                held_address_next = 8'd0;
                held_command_next = 8'd0;
                held_data_next    = 16'd0;
                held_crc_next     = 8'd0;
                byte_count_next   = 3'd0;
                idle_ticks_next   = TICK_MAX;
                crc_acc_next      = 8'd0;
            end
        end
    end

    // Frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_address_reg <= 8'd0;
            held_command_reg <= 8'd0;
            held_data_reg    <= 16'd0;
            held_crc_reg     <= 8'd0;
            byte_count_reg   <= 3'd0;
            idle_ticks_reg   <= TICK_MAX;
            crc_acc_reg      <= 8'd0;
        end
        else
        begin
            held_address_reg <= held_address_next;
            held_command_reg <= held_command_next;
            held_data_reg    <= held_data_next;
            held_crc_reg     <= held_crc_next;
            byte_count_reg   <= byte_count_next;
            idle_ticks_reg   <= idle_ticks_next;
            crc_acc_reg      <= crc_acc_next;
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            master_address_reg <= crc8fr_pkg::MASTER_ADDRESS_RESET;
            timeout_ticks_reg  <= crc8fr_pkg::TIMEOUT_TICKS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                crc8fr_pkg::REG_MASTER_ADDRESS: master_address_reg <= cfg_data[7:0];
                crc8fr_pkg::REG_TIMEOUT_TICKS:  timeout_ticks_reg  <= cfg_data[15:0];
                default:                        master_address_reg <= master_address_reg;
            endcase
        end
    end

    // Output valid: set on a new transaction, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload: load with each accepted item, hold otherwise
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg        <= status_next;
            frame_command_reg <= frame_command_next;
            frame_data_reg    <= frame_data_next;
            frame_crc_reg     <= frame_crc_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign frame_command = frame_command_reg;
    assign frame_data    = frame_data_reg;
    assign frame_crc     = frame_crc_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/crc8fr_checker.sv -----
// ---------------------------------------------------------------------------
// crc8fr_checker
// Port-level checks on the frame receiver, attached by bind.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "crc8_frame_receiver_macros.svh"

module crc8fr_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               in_valid,
    input wire logic                               in_stall,
    input wire logic                               func,
    input wire logic                               out_valid,
    input wire logic                               out_stall,
    input wire logic [1:0]                         status,
    input wire logic [7:0]                         frame_command,
    input wire logic [15:0]                        frame_data,
    input wire logic [7:0]                         frame_crc
);

    logic        in_take;
    logic        tick_take;
    logic        out_wait;
    logic        not_accepted;
    logic        fields_zero;
    logic [33:0] out_payload;

    assign in_take      = in_valid && !in_stall;
    assign tick_take    = in_take && (func == crc8fr_pkg::FUNC_TICK);
    assign out_wait     = out_valid && out_stall;
    assign not_accepted = out_valid && (status != crc8fr_pkg::STATUS_ACCEPT);
    assign fields_zero  = (frame_command == 8'd0) && (frame_data == 16'd0)
                          && (frame_crc == 8'd0);
    assign out_payload  = {status, frame_command, frame_data, frame_crc};

    // Hold a stalled result
    `CRC8FR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_wait, out_valid && $stable(out_payload))

    // Stall the input only while a result waits
    `CRC8FR_ASSERT_NOW(a_stall_cause, clk, rst_n, in_stall, out_wait)

    // Every accepted transaction gives a result in the next cycle
    `CRC8FR_ASSERT_NEXT(a_one_result, clk, rst_n, in_take, out_valid)

    // A tick never reports anything
    `CRC8FR_ASSERT_NEXT(a_tick_quiet, clk, rst_n, tick_take, status == crc8fr_pkg::STATUS_NONE)

    // Frame fields are zero unless a frame was accepted
    `CRC8FR_ASSERT_NOW(a_zero_fields, clk, rst_n, not_accepted, fields_zero)

endmodule

bind crc8_frame_receiver crc8fr_checker u_crc8fr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .func          (func),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .frame_command (frame_command),
    .frame_data    (frame_data),
    .frame_crc     (frame_crc)
);

`default_nettype wire
